>>> hw/rtl/doubly_linked_list_engine_defines.svh
`ifndef DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DLLE_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DLLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dlle_pkg.sv
`timescale 1ns / 1ps

package dlle_pkg;

    localparam int ACTION_BITS = 4;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_APPEND        = 4'd0,
        ACT_PREPEND       = 4'd1,
        ACT_INSERT_BEFORE = 4'd2,
        ACT_INSERT_AFTER  = 4'd3,
        ACT_UNLINK        = 4'd4,
        ACT_UNLINK_ALL    = 4'd5,
        ACT_NEXT          = 4'd6,
        ACT_PREV          = 4'd7,
        ACT_FIND          = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_FIND,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic nxt;
        logic prv;
        logic obj;
        logic busy;
        logic fstk;
    } t_store_we;

endpackage

>>> hw/rtl/doubly_linked_list_engine.sv
// Doubly linked list over a store of NODE_COUNT nodes, addressed by handle.
// Command channel s_*: one action per transfer, result channel m_*: one result
// per action carrying ok, the result handle, the member count, head and tail.
// s_tready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next command transfer.
// Steps after a command transfer: an insert into a non-empty list runs
// S_EXEC, S_LINK, S_DONE; a first insert, a failed insert, unlink, next and
// prev run S_EXEC, S_DONE; an unknown action, or a find for a zero tag or
// in an empty list, goes straight to S_DONE; find walks nodes in S_FIND, one
// per cycle (bound by the link memory read); unlink all runs a clearing pass.
// Reset runs a clearing pass over the in-use bits and the free stack;
// s_tready stays low until it ends. If m_tready stays low, the finished
// result holds in the output register and the sequencer waits in its final
// step with its result until the register is free.
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_defines.svh"

module doubly_linked_list_engine #(
    parameter int  NODE_COUNT = 256,
    parameter int  TAG_BITS   = 32,
    localparam int HW         = $clog2(NODE_COUNT),
    localparam int CW         = $clog2(NODE_COUNT + 1),
    localparam int IN_DW      = ((dlle_pkg::ACTION_BITS + TAG_BITS + HW + 7) / 8) * 8,
    localparam int OUT_DW     = ((3 * HW + CW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // action, object_tag, node_handle
    input  logic [IN_DW-1:0]  s_tdata,
    // handle_is_null
    input  logic [0:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // result_handle, member_count, head_handle, tail_handle
    output logic [OUT_DW-1:0] m_tdata,
    // ok, result_is_null
    output logic [1:0]        m_tuser
);

    import dlle_pkg::*;

    localparam logic [HW-1:0] LAST_IDX   = HW'(NODE_COUNT - 1);
    localparam logic [CW-1:0] FREE_FULL  = CW'(NODE_COUNT);
    localparam logic [HW:0]   NODE_LIMIT = (HW + 1)'(NODE_COUNT);
    localparam int            TAG_LSB    = ACTION_BITS;
    localparam int            HND_LSB    = ACTION_BITS + TAG_BITS;

    logic [ACTION_BITS-1:0] s_action;
    logic [TAG_BITS-1:0]    s_tag;
    logic [HW-1:0]          s_handle;
    logic                   s_hnull;

    t_state                 r_state, n_state;
    logic [ACTION_BITS-1:0] r_act, n_act;
    logic [TAG_BITS-1:0]    r_tag, n_tag;
    logic [HW-1:0]          r_h, n_h;
    logic                   r_hnull, n_hnull;
    logic                   r_ok, n_ok;
    logic                   r_rnull, n_rnull;
    logic [HW-1:0]          r_res, n_res;
    logic [HW-1:0]          r_head, n_head;
    logic [HW-1:0]          r_tail, n_tail;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_free_top, n_free_top;
    logic [HW-1:0]          r_n, n_n;
    logic [HW-1:0]          r_at, n_at;
    logic [HW-1:0]          r_nb, n_nb;
    logic                   r_nb_valid, n_nb_valid;
    logic                   r_before, n_before;
    logic [HW-1:0]          r_e, n_e;
    logic [CW-1:0]          r_i, n_i;
    logic [HW-1:0]          r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    logic                   r_o_ok, n_o_ok;
    logic                   r_o_rnull, n_o_rnull;
    logic [HW-1:0]          r_o_res, n_o_res;
    logic [CW-1:0]          r_o_count, n_o_count;
    logic [HW-1:0]          r_o_head, n_o_head;
    logic [HW-1:0]          r_o_tail, n_o_tail;

    t_store_we              st_we;
    logic [HW-1:0]          st_rd_addr;
    logic [HW-1:0]          st_fstk_rd_addr;
    logic [HW-1:0]          st_nxt_waddr, st_nxt_wdata;
    logic [HW-1:0]          st_prv_waddr, st_prv_wdata;
    logic [HW-1:0]          st_obj_waddr;
    logic [HW-1:0]          st_busy_waddr;
    logic                   st_busy_wdata;
    logic [HW-1:0]          st_fstk_waddr, st_fstk_wdata;
    logic [HW-1:0]          rd_nxt, rd_prv, rd_fstk;
    logic [TAG_BITS-1:0]    rd_obj;
    logic                   rd_busy;

    logic                   h_live;
    logic                   is_insert;
    logic                   ins_before;
    logic                   ins_fallback;
    logic                   ins_go;
    logic [HW-1:0]          ins_at;
    logic                   ins_at_end;
    logic                   unl_go;
    logic                   obj_hit;
    logic                   find_go;
    logic                   out_free;

    assign s_action = s_tdata[ACTION_BITS-1:0];
    assign s_tag    = s_tdata[TAG_LSB +: TAG_BITS];
    assign s_handle = s_tdata[HND_LSB +: HW];
    assign s_hnull  = s_tuser[0];

    dlle_store #(
        .NODE_COUNT (NODE_COUNT),
        .TAG_BITS   (TAG_BITS)
    ) u_store (
        .i_clk          (i_clk),
        .i_we           (st_we),
        .i_rd_addr      (st_rd_addr),
        .i_fstk_rd_addr (st_fstk_rd_addr),
        .i_nxt_waddr    (st_nxt_waddr),
        .i_nxt_wdata    (st_nxt_wdata),
        .i_prv_waddr    (st_prv_waddr),
        .i_prv_wdata    (st_prv_wdata),
        .i_obj_waddr    (st_obj_waddr),
        .i_obj_wdata    (r_tag),
        .i_busy_waddr   (st_busy_waddr),
        .i_busy_wdata   (st_busy_wdata),
        .i_fstk_waddr   (st_fstk_waddr),
        .i_fstk_wdata   (st_fstk_wdata),
        .o_rd_nxt       (rd_nxt),
        .o_rd_prv       (rd_prv),
        .o_rd_obj       (rd_obj),
        .o_rd_busy      (rd_busy),
        .o_rd_fstk      (rd_fstk)
    );

    assign h_live       = ({1'b0, r_h} < NODE_LIMIT) && rd_busy;
    assign is_insert    = (r_act == ACT_APPEND) || (r_act == ACT_PREPEND) ||
                          (r_act == ACT_INSERT_BEFORE) || (r_act == ACT_INSERT_AFTER);
    assign ins_before   = (r_act == ACT_PREPEND) || (r_act == ACT_INSERT_BEFORE);
    assign ins_fallback = (r_act == ACT_APPEND) || (r_act == ACT_PREPEND) ||
                          (r_count == '0) || r_hnull;
    assign ins_go       = (ins_fallback || h_live) && (r_free_top != '0);
    assign ins_at       = ins_fallback ? (ins_before ? r_head : r_tail) : r_h;
    assign ins_at_end   = ins_before ? (ins_at == r_head) : (ins_at == r_tail);
    assign unl_go       = (r_count != '0) && !r_hnull && h_live;
    assign obj_hit      = (rd_obj == r_tag);
    assign find_go      = (s_tag != '0) && (r_count != '0);
    assign out_free     = !r_out_valid || m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_idx == LAST_IDX) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (s_action)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT_BEFORE, ACT_INSERT_AFTER,
                        ACT_UNLINK, ACT_NEXT, ACT_PREV: n_state = S_EXEC;
                        ACT_UNLINK_ALL: n_state = S_CLEAR;
                        ACT_FIND: n_state = find_go ? S_FIND : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EXEC: begin
                n_state = (is_insert && ins_go && (r_count != '0)) ? S_LINK : S_DONE;
            end
            S_LINK: n_state = S_DONE;
            S_FIND: begin
                if (obj_hit || (r_i == r_count - 1'b1)) n_state = S_DONE;
            end
            S_CLEAR: begin
                if (r_idx == LAST_IDX) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_act       = r_act;
        n_tag       = r_tag;
        n_h         = r_h;
        n_hnull     = r_hnull;
        n_ok        = r_ok;
        n_rnull     = r_rnull;
        n_res       = r_res;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_free_top  = r_free_top;
        n_n         = r_n;
        n_at        = r_at;
        n_nb        = r_nb;
        n_nb_valid  = r_nb_valid;
        n_before    = r_before;
        n_e         = r_e;
        n_i         = r_i;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_tready;
        n_o_ok      = r_o_ok;
        n_o_rnull   = r_o_rnull;
        n_o_res     = r_o_res;
        n_o_count   = r_o_count;
        n_o_head    = r_o_head;
        n_o_tail    = r_o_tail;

        st_we           = '0;
        st_rd_addr      = r_h;
        st_fstk_rd_addr = HW'(r_free_top - 1'b1);
        st_nxt_waddr    = r_n;
        st_nxt_wdata    = r_n;
        st_prv_waddr    = r_n;
        st_prv_wdata    = r_n;
        st_obj_waddr    = rd_fstk;
        st_busy_waddr   = r_idx;
        st_busy_wdata   = 1'b0;
        st_fstk_waddr   = r_idx;
        st_fstk_wdata   = LAST_IDX - r_idx;

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                st_we.busy = 1'b1;
                st_we.fstk = 1'b1;
                n_idx      = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_free_top = FREE_FULL;
                    n_head     = '0;
                    n_tail     = '0;
                    n_count    = '0;
                end
            end
            S_IDLE: begin
                st_rd_addr = (s_action == ACT_FIND) ? r_head : s_handle;
                if (s_tvalid) begin
                    n_act   = s_action;
                    n_tag   = s_tag;
                    n_h     = s_handle;
                    n_hnull = s_hnull;
                    n_ok    = (s_action == ACT_UNLINK_ALL) || (s_action == ACT_FIND);
                    n_rnull = 1'b1;
                    n_res   = '0;
                    n_e     = r_head;
                    n_i     = '0;
                    n_idx   = '0;
                end
            end
            S_EXEC: begin
                if (is_insert) begin
                    if (ins_go) begin
                        st_we.obj     = 1'b1;
                        st_we.busy    = 1'b1;
                        st_we.nxt     = 1'b1;
                        st_we.prv     = 1'b1;
                        st_busy_waddr = rd_fstk;
                        st_busy_wdata = 1'b1;
                        st_nxt_waddr  = rd_fstk;
                        st_prv_waddr  = rd_fstk;
                        n_free_top    = r_free_top - 1'b1;
                        n_count       = r_count + 1'b1;
                        n_ok          = 1'b1;
                        n_rnull       = 1'b0;
                        n_res         = rd_fstk;
                        n_n           = rd_fstk;
                        n_at          = ins_at;
                        n_before      = ins_before;
                        n_nb          = ins_before ? rd_prv : rd_nxt;
                        n_nb_valid    = !ins_at_end;
                        if (r_count == '0) begin
                            st_nxt_wdata = '0;
                            st_prv_wdata = '0;
                            n_head       = rd_fstk;
                            n_tail       = rd_fstk;
                        end else if (ins_before) begin
                            st_nxt_wdata = ins_at;
                            st_prv_wdata = ins_at_end ? '0 : rd_prv;
                            if (ins_at_end) n_head = rd_fstk;
                        end else begin
                            st_nxt_wdata = ins_at_end ? '0 : rd_nxt;
                            st_prv_wdata = ins_at;
                            if (ins_at_end) n_tail = rd_fstk;
                        end
                    end
                end else if (r_act == ACT_UNLINK) begin
                    if (unl_go) begin
                        n_ok          = 1'b1;
                        st_we.busy    = 1'b1;
                        st_busy_waddr = r_h;
                        st_busy_wdata = 1'b0;
                        st_nxt_waddr  = rd_prv;
                        st_nxt_wdata  = rd_nxt;
                        st_prv_waddr  = rd_nxt;
                        st_prv_wdata  = rd_prv;
                        if (r_h == r_head) n_head = rd_nxt;
                        else st_we.nxt = 1'b1;
                        if (r_h == r_tail) n_tail = rd_prv;
                        else st_we.prv = 1'b1;
                        if (r_free_top < FREE_FULL) begin
                            st_we.fstk    = 1'b1;
                            st_fstk_waddr = HW'(r_free_top);
                            st_fstk_wdata = r_h;
                            n_free_top    = r_free_top + 1'b1;
                        end
                        n_count = r_count - 1'b1;
                        if (r_count == CW'(1)) begin
                            n_head = '0;
                            n_tail = '0;
                        end
                    end
                end else if ((r_act == ACT_NEXT) || (r_act == ACT_PREV)) begin
                    if (!r_hnull && h_live) begin
                        n_ok = 1'b1;
                        if ((r_act == ACT_NEXT) && (r_h != r_tail)) begin
                            n_res   = rd_nxt;
                            n_rnull = 1'b0;
                        end else if ((r_act == ACT_PREV) && (r_h != r_head)) begin
                            n_res   = rd_prv;
                            n_rnull = 1'b0;
                        end
                    end
                end
            end
            S_LINK: begin
                if (r_before) begin
                    st_we.prv    = 1'b1;
                    st_prv_waddr = r_at;
                    st_we.nxt    = r_nb_valid;
                    st_nxt_waddr = r_nb;
                end else begin
                    st_we.nxt    = 1'b1;
                    st_nxt_waddr = r_at;
                    st_we.prv    = r_nb_valid;
                    st_prv_waddr = r_nb;
                end
            end
            S_FIND: begin
                st_rd_addr = rd_nxt;
                if (obj_hit) begin
                    n_res   = r_e;
                    n_rnull = 1'b0;
                end else begin
                    n_e = rd_nxt;
                    n_i = r_i + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_ok      = r_ok;
                    n_o_rnull   = r_rnull;
                    n_o_res     = r_res;
                    n_o_count   = r_count;
                    n_o_head    = r_head;
                    n_o_tail    = r_tail;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free_top  <= FREE_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free_top  <= n_free_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_tag      <= n_tag;
        r_h        <= n_h;
        r_hnull    <= n_hnull;
        r_ok       <= n_ok;
        r_rnull    <= n_rnull;
        r_res      <= n_res;
        r_n        <= n_n;
        r_at       <= n_at;
        r_nb       <= n_nb;
        r_nb_valid <= n_nb_valid;
        r_before   <= n_before;
        r_e        <= n_e;
        r_i        <= n_i;
        r_o_ok     <= n_o_ok;
        r_o_rnull  <= n_o_rnull;
        r_o_res    <= n_o_res;
        r_o_count  <= n_o_count;
        r_o_head   <= n_o_head;
        r_o_tail   <= n_o_tail;
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tuser  = {r_o_rnull, r_o_ok};

    always_comb begin
        m_tdata                       = '0;
        m_tdata[HW-1:0]               = r_o_res;
        m_tdata[HW +: CW]             = r_o_count;
        m_tdata[HW + CW +: HW]        = r_o_head;
        m_tdata[2 * HW + CW +: HW]    = r_o_tail;
    end

    `DLLE_ASSERT_HOLD(a_free_balance, 1'b1, (32'(r_free_top) + 32'(r_count) == NODE_COUNT), "free stack and member count out of balance")
    `DLLE_ASSERT_HOLD(a_empty_ends, (r_count == '0), ((r_head == '0) && (r_tail == '0)), "empty list with nonzero head or tail")
    `DLLE_ASSERT_HOLD(a_find_bound, (r_state == S_FIND), (r_i < r_count), "find walked past the list length")
    `DLLE_ASSERT_NEXT(a_alloc_pop, ((r_state == S_EXEC) && is_insert && ins_go), (r_free_top == $past(r_free_top) - 1'b1), "allocation did not pop the free stack")

endmodule

>>> hw/rtl/dlle_store.sv
`timescale 1ns / 1ps

module dlle_store #(
    parameter int  NODE_COUNT = 256,
    parameter int  TAG_BITS   = 32,
    localparam int HW         = $clog2(NODE_COUNT)
) (
    input  logic                i_clk,
    input  dlle_pkg::t_store_we i_we,
    input  logic [HW-1:0]       i_rd_addr,
    input  logic [HW-1:0]       i_fstk_rd_addr,
    input  logic [HW-1:0]       i_nxt_waddr,
    input  logic [HW-1:0]       i_nxt_wdata,
    input  logic [HW-1:0]       i_prv_waddr,
    input  logic [HW-1:0]       i_prv_wdata,
    input  logic [HW-1:0]       i_obj_waddr,
    input  logic [TAG_BITS-1:0] i_obj_wdata,
    input  logic [HW-1:0]       i_busy_waddr,
    input  logic                i_busy_wdata,
    input  logic [HW-1:0]       i_fstk_waddr,
    input  logic [HW-1:0]       i_fstk_wdata,
    output logic [HW-1:0]       o_rd_nxt,
    output logic [HW-1:0]       o_rd_prv,
    output logic [TAG_BITS-1:0] o_rd_obj,
    output logic                o_rd_busy,
    output logic [HW-1:0]       o_rd_fstk
);

    import dlle_pkg::*;

    logic [HW-1:0]       r_nxt_mem  [NODE_COUNT];
    logic [HW-1:0]       r_prv_mem  [NODE_COUNT];
    logic [TAG_BITS-1:0] r_obj_mem  [NODE_COUNT];
    logic                r_busy_mem [NODE_COUNT];
    logic [HW-1:0]       r_fstk_mem [NODE_COUNT];

    logic [HW-1:0]       r_rd_nxt;
    logic [HW-1:0]       r_rd_prv;
    logic [TAG_BITS-1:0] r_rd_obj;
    logic                r_rd_busy;
    logic [HW-1:0]       r_rd_fstk;

    always_ff @(posedge i_clk) begin
        if (i_we.nxt) begin
            r_nxt_mem[i_nxt_waddr] <= i_nxt_wdata;
        end
        r_rd_nxt <= r_nxt_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.prv) begin
            r_prv_mem[i_prv_waddr] <= i_prv_wdata;
        end
        r_rd_prv <= r_prv_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.obj) begin
            r_obj_mem[i_obj_waddr] <= i_obj_wdata;
        end
        r_rd_obj <= r_obj_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.busy) begin
            r_busy_mem[i_busy_waddr] <= i_busy_wdata;
        end
        r_rd_busy <= r_busy_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.fstk) begin
            r_fstk_mem[i_fstk_waddr] <= i_fstk_wdata;
        end
        r_rd_fstk <= r_fstk_mem[i_fstk_rd_addr];
    end

    assign o_rd_nxt  = r_rd_nxt;
    assign o_rd_prv  = r_rd_prv;
    assign o_rd_obj  = r_rd_obj;
    assign o_rd_busy = r_rd_busy;
    assign o_rd_fstk = r_rd_fstk;

endmodule

>>> tb/tb_doubly_linked_list_engine.sv
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine;
    import dlle_pkg::*;

    localparam int NODES    = 256;
    localparam int TAG_W    = 32;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 40;
    localparam int HOLD_LEN = 400;

    typedef struct {
        logic [3:0]       act;
        logic [TAG_W-1:0] tag;
        logic [7:0]       hnd;
        logic             hnull;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [7:0] hnd;
        logic       nul;
        logic [8:0] cnt;
        logic [7:0] head;
        logic [7:0] tail;
    } t_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    // shadow of the node store
    logic [7:0]       link_nxt [NODES];
    logic [7:0]       link_prv [NODES];
    logic [TAG_W-1:0] node_tag [NODES];
    bit               node_used [NODES];
    logic [7:0]       free_stk [NODES];
    int               free_cnt;
    logic [7:0]       list_head;
    logic [7:0]       list_tail;
    int               list_len;

    t_cmd     cmd_q[$];
    t_outcome outcome_q[$];

    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;

    int err_cnt = 0;
    int checked = 0;
    int sent = 0;
    int act_seen [16];
    int full_refused = 0;
    int max_len = 0;
    int idle_tab  [4] = '{0, 65, 0, 36};
    int stall_tab [4] = '{0, 0, 65, 36};
    int len_tab   [4] = '{300, 450, 300, 300};

    doubly_linked_list_engine #(
        .NODE_COUNT(NODES),
        .TAG_BITS(TAG_W)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d commands sent, %0d results checked, %0d pending",
                 sent, checked, outcome_q.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic void store_clear();
        for (int i = 0; i < NODES; i++) begin
            free_stk[i] = 8'(NODES - 1 - i);
            node_used[i] = 1'b0;
        end
        free_cnt = NODES;
        list_head = '0;
        list_tail = '0;
        list_len = 0;
    endfunction

    function automatic t_outcome list_apply(t_cmd c);
        t_outcome r;
        logic [7:0] n, p, q, at, e;
        bit fb, bef;
        r.ok = 1'b0;
        r.hnd = '0;
        r.nul = 1'b1;
        if (c.act <= ACT_INSERT_AFTER) begin
            bef = (c.act == ACT_PREPEND) || (c.act == ACT_INSERT_BEFORE);
            fb = (c.act <= ACT_PREPEND) || (list_len == 0) || c.hnull;
            if ((fb || node_used[c.hnd]) && free_cnt > 0) begin
                free_cnt--;
                n = free_stk[free_cnt];
                node_tag[n] = c.tag;
                node_used[n] = 1'b1;
                link_nxt[n] = '0;
                link_prv[n] = '0;
                list_len++;
                if (list_len == 1) begin
                    list_head = n;
                    list_tail = n;
                end else begin
                    at = fb ? (bef ? list_head : list_tail) : c.hnd;
                    if (bef) begin
                        if (at == list_head) begin
                            list_head = n;
                            link_prv[n] = '0;
                        end else begin
                            p = link_prv[at];
                            link_nxt[p] = n;
                            link_prv[n] = p;
                        end
                        link_nxt[n] = at;
                        link_prv[at] = n;
                    end else begin
                        if (at == list_tail) begin
                            list_tail = n;
                            link_nxt[n] = '0;
                        end else begin
                            q = link_nxt[at];
                            link_prv[q] = n;
                            link_nxt[n] = q;
                        end
                        link_prv[n] = at;
                        link_nxt[at] = n;
                    end
                end
                r.ok = 1'b1;
                r.nul = 1'b0;
                r.hnd = n;
            end else if (free_cnt == 0) begin
                full_refused++;
            end
        end else if (c.act == ACT_UNLINK) begin
            if (list_len != 0 && !c.hnull && node_used[c.hnd]) begin
                p = link_prv[c.hnd];
                q = link_nxt[c.hnd];
                if (c.hnd == list_head) list_head = q;
                else link_nxt[p] = q;
                if (c.hnd == list_tail) list_tail = p;
                else link_prv[q] = p;
                node_used[c.hnd] = 1'b0;
                if (free_cnt < NODES) begin
                    free_stk[free_cnt] = c.hnd;
                    free_cnt++;
                end
                list_len--;
                if (list_len == 0) begin
                    list_head = '0;
                    list_tail = '0;
                end
                r.ok = 1'b1;
            end
        end else if (c.act == ACT_UNLINK_ALL) begin
            store_clear();
            r.ok = 1'b1;
        end else if (c.act == ACT_NEXT || c.act == ACT_PREV) begin
            if (!c.hnull && node_used[c.hnd]) begin
                r.ok = 1'b1;
                if (c.act == ACT_NEXT && c.hnd != list_tail) begin
                    r.hnd = link_nxt[c.hnd];
                    r.nul = 1'b0;
                end else if (c.act == ACT_PREV && c.hnd != list_head) begin
                    r.hnd = link_prv[c.hnd];
                    r.nul = 1'b0;
                end
            end
        end else if (c.act == ACT_FIND) begin
            r.ok = 1'b1;
            if (c.tag != 0) begin
                e = list_head;
                for (int i = 0; i < list_len; i++) begin
                    if (node_tag[e] == c.tag) begin
                        r.hnd = e;
                        r.nul = 1'b0;
                        break;
                    end
                    e = link_nxt[e];
                end
            end
        end
        r.cnt = 9'(list_len);
        r.head = list_head;
        r.tail = list_tail;
        if (list_len > max_len) max_len = list_len;
        return r;
    endfunction

    function automatic void push_cmd(t_cmd c);
        act_seen[c.act]++;
        outcome_q.push_back(list_apply(c));
        cmd_q.push_back(c);
    endfunction

    function automatic void add(logic [3:0] act, logic [TAG_W-1:0] tag, logic [7:0] hnd,
                                logic hnull);
        t_cmd c;
        c.act = act;
        c.tag = tag;
        c.hnd = hnd;
        c.hnull = hnull;
        push_cmd(c);
    endfunction

    function automatic logic [7:0] live_pick();
        logic [7:0] e;
        e = list_head;
        repeat ($urandom_range(list_len - 1)) e = link_nxt[e];
        return e;
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 45) return $urandom_range(12, 1);
        if (r < 95) return $urandom;
        return '0;
    endfunction

    function automatic t_cmd rand_cmd(bit grow);
        t_cmd c;
        int r, s;
        r = $urandom_range(99);
        s = $urandom_range(99);
        c.tag = pick_tag();
        c.hnull = ($urandom_range(9) == 0);
        c.hnd = 8'($urandom_range(255));
        if (list_len > 0 && $urandom_range(99) < 85) c.hnd = live_pick();
        if (r < (grow ? 75 : 45)) begin
            c.act = 4'($urandom_range(ACT_INSERT_AFTER, ACT_APPEND));
        end else if (s < 35) begin
            c.act = ACT_UNLINK;
        end else if (s < 55) begin
            c.act = ACT_NEXT;
        end else if (s < 75) begin
            c.act = ACT_PREV;
        end else if (s < 92 || (grow && s >= 97)) begin
            c.act = ACT_FIND;
            if (list_len > 0 && $urandom_range(99) < 70) c.tag = node_tag[live_pick()];
        end else if (s < 97) begin
            c.act = 4'($urandom_range(15, ACT_FIND + 1));
        end else begin
            c.act = ACT_UNLINK_ALL;
        end
        return c;
    endfunction

    function automatic void flag_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    task automatic drain();
        while (cmd_q.size() > 0 || s_tvalid || outcome_q.size() > 0) @(posedge i_clk);
    endtask

    // sender: hold the current command until transfer, then advance
    always @(posedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) sent++;
            if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                c = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, c.hnd, c.tag, c.act};
                s_tuser <= c.hnull;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.ok = m_tuser[0];
            got.nul = m_tuser[1];
            got.hnd = m_tdata[7:0];
            got.cnt = m_tdata[16:8];
            got.head = m_tdata[24:17];
            got.tail = m_tdata[32:25];
            checked++;
            if (outcome_q.size() == 0) begin
                flag_error($sformatf("unexpected result ok=%0b hnd=%0d nul=%0b cnt=%0d",
                                     got.ok, got.hnd, got.nul, got.cnt));
            end else begin
                want = outcome_q.pop_front();
                if (got.ok !== want.ok || got.hnd !== want.hnd || got.nul !== want.nul ||
                    got.cnt !== want.cnt || got.head !== want.head || got.tail !== want.tail)
                    flag_error($sformatf({"result %0d: exp ok=%0b hnd=%0d nul=%0b cnt=%0d ",
                        "head=%0d tail=%0d, got ok=%0b hnd=%0d nul=%0b cnt=%0d head=%0d tail=%0d"},
                        checked, want.ok, want.hnd, want.nul, want.cnt, want.head, want.tail,
                        got.ok, got.hnd, got.nul, got.cnt, got.head, got.tail));
            end
        end
    end

    initial begin
        store_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add(ACT_UNLINK, 32'd0, 8'd0, 1'b0);
        add(ACT_NEXT, 32'd3, 8'd0, 1'b1);
        add(ACT_FIND, 32'd5, 8'd0, 1'b0);
        add(ACT_INSERT_BEFORE, 32'd1, 8'd200, 1'b0);
        add(ACT_INSERT_AFTER, 32'hFFFF_FFFF, 8'd0, 1'b1);
        add(ACT_APPEND, 32'd0, 8'd0, 1'b0);
        add(ACT_PREPEND, 32'd5, 8'd255, 1'b0);
        add(ACT_INSERT_BEFORE, 32'd7, 8'd1, 1'b0);
        add(ACT_INSERT_AFTER, 32'd9, 8'd2, 1'b0);
        add(ACT_INSERT_AFTER, 32'd4, 8'd255, 1'b0);
        add(ACT_INSERT_BEFORE, 32'd5, 8'd3, 1'b0);
        add(ACT_NEXT, 32'd0, 8'd5, 1'b0);
        add(ACT_PREV, 32'd0, 8'd6, 1'b0);
        add(ACT_NEXT, 32'd0, 8'd0, 1'b0);
        add(ACT_PREV, 32'd0, 8'd1, 1'b0);
        add(ACT_PREV, 32'd0, 8'd255, 1'b0);
        add(ACT_FIND, 32'd0, 8'd0, 1'b0);
        add(ACT_FIND, 32'hFFFF_FFFF, 8'd0, 1'b0);
        add(ACT_FIND, 32'h8000_0000, 8'd0, 1'b0);
        add(ACT_UNLINK, 32'd0, 8'd0, 1'b1);
        add(ACT_UNLINK, 32'd0, 8'd255, 1'b0);
        add(ACT_UNLINK, 32'd0, 8'd6, 1'b0);
        add(ACT_UNLINK, 32'd0, 8'd5, 1'b0);
        add(ACT_UNLINK, 32'd0, 8'd4, 1'b0);
        add(4'(ACT_FIND + 1), 32'd0, 8'd0, 1'b0);
        add(4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        add(ACT_UNLINK_ALL, 32'd0, 8'd0, 1'b0);
        add(ACT_APPEND, 32'h1234_5678, 8'd0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct <= idle_tab[ph];
            stall_pct <= stall_tab[ph];
            if (ph == 2) hold_req <= 1'b1;
            @(posedge i_clk);
            repeat (len_tab[ph]) push_cmd(rand_cmd(ph == 1));
            drain();
        end

        repeat (NODES + 20) @(posedge i_clk);
        if (outcome_q.size() != 0) flag_error($sformatf("%0d results missing", outcome_q.size()));

        $display("%0d commands through, %0d results checked, list up to %0d long, %0d %0s",
                 sent, checked, max_len, full_refused, "inserts refused on a full store");
        $display("%s", $sformatf({"mix: append %0d prepend %0d before %0d after %0d ",
                 "unlink %0d unlink_all %0d next %0d prev %0d find %0d"},
                 act_seen[ACT_APPEND], act_seen[ACT_PREPEND], act_seen[ACT_INSERT_BEFORE],
                 act_seen[ACT_INSERT_AFTER], act_seen[ACT_UNLINK], act_seen[ACT_UNLINK_ALL],
                 act_seen[ACT_NEXT], act_seen[ACT_PREV], act_seen[ACT_FIND]));
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
